// ===== src/mkcd_pkg.sv =====
// ----------------------------------------------------------------------------
// mkcd_pkg
// Shared widths, flag codes, reset values and types of the key click detector.
// ----------------------------------------------------------------------------
package mkcd_pkg;

  localparam int NUM_KEYS_DEF = 4;
  localparam int PIN_W        = 4;
  localparam int IDX_W        = 2;
  localparam int FLAG_W       = 7;
  localparam int TIMER_W      = 16;
  localparam int SP_W         = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  // flag bit codes
  localparam logic [FLAG_W-1:0] FL_HOLD   = 7'h01;
  localparam logic [FLAG_W-1:0] FL_DOWN   = 7'h02;
  localparam logic [FLAG_W-1:0] FL_UP     = 7'h04;
  localparam logic [FLAG_W-1:0] FL_SINGLE = 7'h08;
  localparam logic [FLAG_W-1:0] FL_DOUBLE = 7'h10;
  localparam logic [FLAG_W-1:0] FL_LONG   = 7'h20;
  localparam logic [FLAG_W-1:0] FL_REPEAT = 7'h40;

  // operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG   = 2'd0,
    REG_DOUBLE = 2'd1,
    REG_REPEAT = 2'd2,
    REG_PERIOD = 2'd3
  } cfg_reg_t;

  // register reset values
  localparam logic [TIMER_W-1:0] LONG_RST   = 16'd2000;
  localparam logic [TIMER_W-1:0] DOUBLE_RST = 16'd200;
  localparam logic [TIMER_W-1:0] REPEAT_RST = 16'd100;
  localparam logic [SP_W-1:0]    PERIOD_RST = 8'd20;

  typedef struct packed {
    logic [TIMER_W-1:0] long_ticks;
    logic [TIMER_W-1:0] double_ticks;
    logic [TIMER_W-1:0] repeat_ticks;
  } dur_cfg_t;

  typedef struct packed {
    logic              tick;
    logic              sample;
    logic              now;
    logic              clear;
    logic [FLAG_W-1:0] clr_mask;
  } lane_ctl_t;

endpackage

// ===== src/mkcd_if.sv =====
// ----------------------------------------------------------------------------
// mkcd channel interfaces
// Valid/ready channels for the item words and the result words.
// ----------------------------------------------------------------------------
interface mkcd_in_if import mkcd_pkg::*;;
  logic              valid;
  logic              ready;
  logic              op;
  logic [PIN_W-1:0]  pin_levels;
  logic [IDX_W-1:0]  key_index;
  logic [FLAG_W-1:0] flag_mask;

  modport source (output valid, output op, output pin_levels, output key_index,
                  output flag_mask, input ready);
  modport sink (input valid, input op, input pin_levels, input key_index,
                input flag_mask, output ready);
endinterface

interface mkcd_out_if import mkcd_pkg::*;;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [FLAG_W-1:0] key_flags;

  modport source (output valid, output hit, output key_flags, input ready);
  modport sink (input valid, input hit, input key_flags, output ready);
endinterface

// ===== src/mkcd_key_lane.sv =====
// ----------------------------------------------------------------------------
// mkcd_key_lane
// Per-key timer, flags and click state machine.
// ----------------------------------------------------------------------------
module mkcd_key_lane import mkcd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dur_cfg_t          dur,
  input  lane_ctl_t         ctl,
  output logic [FLAG_W-1:0] flags
);

  typedef enum logic [4:0] {
    MODE_IDLE     = 5'b00001,
    MODE_PRESSED  = 5'b00010,
    MODE_RELEASED = 5'b00100,
    MODE_DOUBLE   = 5'b01000,
    MODE_LONG     = 5'b10000
  } mode_t;

  mode_t              mode_r, mode_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt, timer_dec;
  logic [FLAG_W-1:0]  flags_r, flags_nxt;
  logic               cur_r, cur_nxt;
  logic               expired;

  assign timer_dec = (ctl.tick && timer_r != '0) ? timer_r - 1'b1 : timer_r;
  assign expired   = (timer_dec == '0);

  always_comb begin
    mode_nxt  = mode_r;
    timer_nxt = timer_dec;
    flags_nxt = flags_r;
    cur_nxt   = cur_r;
    if (ctl.clear) begin
      flags_nxt = flags_r & ~ctl.clr_mask;
    end
    if (ctl.sample) begin
      cur_nxt  = ctl.now;
      if (ctl.now) begin
        flags_nxt = flags_nxt | FL_HOLD;
      end else begin
        flags_nxt = flags_nxt & ~FL_HOLD;
      end
      if (ctl.now && !cur_r) begin
        flags_nxt = flags_nxt | FL_DOWN;
      end
      if (!ctl.now && cur_r) begin
        flags_nxt = flags_nxt | FL_UP;
      end
      case (mode_r)
        MODE_IDLE: begin
          if (ctl.now) begin
            timer_nxt = dur.long_ticks;
            mode_nxt  = MODE_PRESSED;
          end
        end
        MODE_PRESSED: begin
          if (!ctl.now) begin
            timer_nxt = dur.double_ticks;
            mode_nxt  = MODE_RELEASED;
          end else if (expired) begin
            timer_nxt = dur.repeat_ticks;
            flags_nxt = flags_nxt | FL_LONG;
            mode_nxt  = MODE_LONG;
          end
        end
        MODE_RELEASED: begin
          if (ctl.now) begin
            flags_nxt = flags_nxt | FL_DOUBLE;
            mode_nxt  = MODE_DOUBLE;
          end else if (expired) begin
            flags_nxt = flags_nxt | FL_SINGLE;
            mode_nxt  = MODE_IDLE;
          end
        end
        MODE_DOUBLE: begin
          if (!ctl.now) begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_LONG: begin
          if (!ctl.now) begin
            mode_nxt = MODE_IDLE;
          end else if (expired) begin
            timer_nxt = dur.repeat_ticks;
            flags_nxt = flags_nxt | FL_REPEAT;
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      timer_r <= '0;
      flags_r <= '0;
      cur_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      timer_r <= timer_nxt;
      flags_r <= flags_nxt;
      cur_r   <= cur_nxt;
    end
  end

  assign flags = flags_r;

endmodule

// ===== src/mkcd_merge.sv =====
// ----------------------------------------------------------------------------
// mkcd_merge
// Picks the addressed lane's flags, decides hit and clear, holds the result.
// ----------------------------------------------------------------------------
module mkcd_merge import mkcd_pkg::*; #(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic                             op,
  input  logic [IDX_W-1:0]                 key_index,
  input  logic [FLAG_W-1:0]                flag_mask,
  input  logic [NUM_KEYS-1:0][FLAG_W-1:0]  lane_flags,
  input  logic                             res_ready,
  output logic                             take_ok,
  output logic [NUM_KEYS-1:0]              lane_clear,
  output logic                             res_valid,
  output logic                             res_hit,
  output logic [FLAG_W-1:0]                res_flags
);

  logic [FLAG_W-1:0]   sel_flags;
  logic [NUM_KEYS-1:0] sel_hot;
  logic                hit;
  logic                valid_r, valid_nxt;
  logic                hit_r, hit_nxt;
  logic [FLAG_W-1:0]   flags_r, flags_nxt;

  // one-hot lane select; an index past the last lane selects nothing
  always_comb begin
    sel_flags = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      sel_hot[k] = (int'(key_index) == k);
      if (sel_hot[k]) begin
        sel_flags = sel_flags | lane_flags[k];
      end
    end
  end

  assign hit = (op == OP_CHECK) && ((sel_flags & flag_mask) != '0);

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      lane_clear[k] = accept && hit && (flag_mask != FL_HOLD) && sel_hot[k];
    end
  end

  assign take_ok = !valid_r || res_ready;

  always_comb begin
    valid_nxt = valid_r;
    hit_nxt   = hit_r;
    flags_nxt = flags_r;
    if (accept) begin
      valid_nxt = 1'b1;
      hit_nxt   = hit;
      flags_nxt = (op == OP_CHECK) ? sel_flags : '0;
    end else if (res_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    hit_r   <= hit_nxt;
    flags_r <= flags_nxt;
  end

  assign res_valid = valid_r;
  assign res_hit   = hit_r;
  assign res_flags = flags_r;

endmodule

// ===== src/multi_key_click_event_detector.sv =====
// ----------------------------------------------------------------------------
// multi_key_click_event_detector
// Key click detector: hold, edges, single, double, long and repeat per key.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in_ch    in         valid/ready        op, pin_levels, key_index, flag_mask
//  out_ch   out        valid/ready        hit, key_flags
//  cfg_*    in         cfg_we (no ready)  cfg_idx, cfg_data
//
//  one word accepted per cycle; its result shows in the next cycle from the
//  output register, and a new word is taken while out_ch.ready is high or
//  the output register is empty
//  all key lanes update in the accepting cycle, so a following word sees them
//  rst_n is synchronous: config back to defaults, all keys idle, flags clear
// ----------------------------------------------------------------------------
module multi_key_click_event_detector import mkcd_pkg::*; #(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mkcd_in_if.sink               in_ch,
  mkcd_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dur_cfg_t                     dur_r;
  logic [SP_W-1:0]              period_r;
  logic [SP_W-1:0]              cnt_r, cnt_nxt, cnt_inc;
  logic                         accept, tick, sample, take_ok;
  logic [NUM_KEYS-1:0]          lane_clear;
  logic [NUM_KEYS-1:0][FLAG_W-1:0] lane_flags;

  assign in_ch.ready = take_ok;
  assign accept      = in_ch.valid && take_ok;
  assign tick        = accept && (in_ch.op == OP_TICK);

  // sample counter: wraps back to zero when the period is reached
  assign cnt_inc = cnt_r + 1'b1;
  assign sample  = tick && (cnt_inc >= period_r);

  always_comb begin
    cnt_nxt = cnt_r;
    if (tick) begin
      cnt_nxt = sample ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r.long_ticks   <= LONG_RST;
      dur_r.double_ticks <= DOUBLE_RST;
      dur_r.repeat_ticks <= REPEAT_RST;
      period_r           <= PERIOD_RST;
      cnt_r              <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_LONG:   dur_r.long_ticks   <= cfg_data;
          REG_DOUBLE: dur_r.double_ticks <= cfg_data;
          REG_REPEAT: dur_r.repeat_ticks <= cfg_data;
          REG_PERIOD: period_r           <= cfg_data[SP_W-1:0];
          default:    period_r           <= period_r;
        endcase
      end
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    lane_ctl_t ctl;
    logic      now;

    // keys without a pin read as released
    if (k < PIN_W) begin : g_pin
      assign now = !in_ch.pin_levels[k];
    end else begin : g_nopin
      assign now = 1'b0;
    end

    assign ctl.tick     = tick;
    assign ctl.sample   = sample;
    assign ctl.now      = now;
    assign ctl.clear    = lane_clear[k];
    assign ctl.clr_mask = in_ch.flag_mask;

    mkcd_key_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .dur   (dur_r),
      .ctl   (ctl),
      .flags (lane_flags[k])
    );
  end

  mkcd_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .op         (in_ch.op),
    .key_index  (in_ch.key_index),
    .flag_mask  (in_ch.flag_mask),
    .lane_flags (lane_flags),
    .res_ready  (out_ch.ready),
    .take_ok    (take_ok),
    .lane_clear (lane_clear),
    .res_valid  (out_ch.valid),
    .res_hit    (out_ch.hit),
    .res_flags  (out_ch.key_flags)
  );

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives tick and check words into the key click detector under random
// valid/ready pressure, predicts every answer from its own copy of the key
// lanes and compares each result field by field.
// ----------------------------------------------------------------------------
import mkcd_pkg::*;

typedef enum logic [2:0] {
  MODE_IDLE,
  MODE_PRESSED,
  MODE_RELEASED,
  MODE_DOUBLE,
  MODE_LONG
} key_mode_e;

typedef struct packed {
  logic              hit;
  logic [FLAG_W-1:0] key_flags;
} check_answer_t;

class click_scoreboard;
  localparam int NK = NUM_KEYS_DEF;

  logic [TIMER_W-1:0] long_ticks;
  logic [TIMER_W-1:0] double_ticks;
  logic [TIMER_W-1:0] repeat_ticks;
  logic [SP_W-1:0]    period;

  logic [TIMER_W-1:0] timer[NK];
  logic [FLAG_W-1:0]  flags[NK];
  key_mode_e          mode[NK];
  bit                 is_down[NK];
  bit                 was_down[NK];
  logic [SP_W-1:0]    sample_cnt;

  check_answer_t      due_answers[$];
  int                 errors;
  int                 words_in;

  function new();
    long_ticks   = LONG_RST;
    double_ticks = DOUBLE_RST;
    repeat_ticks = REPEAT_RST;
    period       = PERIOD_RST;
    for (int k = 0; k < NK; k++) begin
      timer[k]    = '0;
      flags[k]    = '0;
      mode[k]     = MODE_IDLE;
      is_down[k]  = 0;
      was_down[k] = 0;
    end
    sample_cnt = '0;
    errors     = 0;
    words_in   = 0;
  endfunction

  function void write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] data);
    case (r)
      REG_LONG:   long_ticks   = data;
      REG_DOUBLE: double_ticks = data;
      REG_REPEAT: repeat_ticks = data;
      REG_PERIOD: period       = data[SP_W-1:0];
      default: ;
    endcase
  endfunction

  function void sample_key(int k, logic [PIN_W-1:0] pins);
    logic [FLAG_W-1:0] fl;
    bit                now;
    fl  = flags[k];
    now = (k < PIN_W) ? !pins[k] : 1'b0;
    was_down[k] = is_down[k];
    is_down[k]  = now;
    if (now) fl = fl | FL_HOLD;
    else fl = fl & ~FL_HOLD;
    if (now && !was_down[k]) fl = fl | FL_DOWN;
    if (!now && was_down[k]) fl = fl | FL_UP;
    case (mode[k])
      MODE_IDLE: begin
        if (now) begin
          timer[k] = long_ticks;
          mode[k]  = MODE_PRESSED;
        end
      end
      MODE_PRESSED: begin
        if (!now) begin
          timer[k] = double_ticks;
          mode[k]  = MODE_RELEASED;
        end else if (timer[k] == 0) begin
          timer[k] = repeat_ticks;
          fl       = fl | FL_LONG;
          mode[k]  = MODE_LONG;
        end
      end
      MODE_RELEASED: begin
        if (now) begin
          fl      = fl | FL_DOUBLE;
          mode[k] = MODE_DOUBLE;
        end else if (timer[k] == 0) begin
          fl      = fl | FL_SINGLE;
          mode[k] = MODE_IDLE;
        end
      end
      MODE_DOUBLE: begin
        if (!now) mode[k] = MODE_IDLE;
      end
      MODE_LONG: begin
        if (!now) begin
          mode[k] = MODE_IDLE;
        end else if (timer[k] == 0) begin
          timer[k] = repeat_ticks;
          fl       = fl | FL_REPEAT;
        end
      end
      default: ;
    endcase
    flags[k] = fl;
  endfunction

  function void note_word(logic op, logic [PIN_W-1:0] pins, logic [IDX_W-1:0] idx,
                          logic [FLAG_W-1:0] mask);
    check_answer_t ans;
    ans = '0;
    words_in++;
    if (op == OP_TICK) begin
      for (int k = 0; k < NK; k++)
        if (timer[k] != 0) timer[k] = timer[k] - 1'b1;
      sample_cnt = sample_cnt + 1'b1;
      if (sample_cnt >= period) begin
        sample_cnt = '0;
        for (int k = 0; k < NK; k++) sample_key(k, pins);
      end
    end else if (int'(idx) < NK) begin
      ans.key_flags = flags[idx];
      if ((flags[idx] & mask) != 0) begin
        ans.hit = 1'b1;
        // a hold-only query leaves the flags alone
        if (mask != FL_HOLD) flags[idx] = flags[idx] & ~mask;
      end
    end
    due_answers.push_back(ans);
  endfunction

  function void check_answer(logic hit, logic [FLAG_W-1:0] key_flags);
    check_answer_t want;
    if (due_answers.size() == 0) begin
      $error("result word with nothing pending: hit %0d key_flags 0x%0h", hit, key_flags);
      errors++;
      return;
    end
    want = due_answers.pop_front();
    if (hit !== want.hit) begin
      $error("hit: expected %0d, got %0d", want.hit, hit);
      errors++;
    end
    if (key_flags !== want.key_flags) begin
      $error("key_flags: expected 0x%0h, got 0x%0h", want.key_flags, key_flags);
      errors++;
    end
  endfunction

  function int pending();
    return due_answers.size();
  endfunction

  function void close_out();
    if (due_answers.size() != 0) begin
      $error("%0d result words never arrived", due_answers.size());
      errors++;
    end
  endfunction
endclass

module tb_top;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  mkcd_in_if  in_if ();
  mkcd_out_if out_if ();

  multi_key_click_event_detector uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  click_scoreboard sb = new();

  bit calm = 0;
  bit held_off = 0;

  // key press pattern that persists across ticks
  logic [PIN_W-1:0] pins_now = '1;
  int               run_left[PIN_W];
  int               ph_long, ph_double, ph_repeat, ph_period;

  always #6 clk = ~clk;

  initial begin
    #(12 * 600000);
    $display("tb_top NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_answer(out_if.hit, out_if.key_flags);
  end

  // result side: short random stalls plus one long hold-off
  initial begin
    out_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!held_off && sb.words_in >= 400) begin
        out_if.ready <= 1'b0;
        repeat (80) @(posedge clk);
        out_if.ready <= 1'b1;
        held_off = 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic op, input logic [PIN_W-1:0] pins,
                           input logic [IDX_W-1:0] idx, input logic [FLAG_W-1:0] mask);
    in_if.valid      <= 1'b1;
    in_if.op         <= op;
    in_if.pin_levels <= pins;
    in_if.key_index  <= idx;
    in_if.flag_mask  <= mask;
    do @(posedge clk); while (!in_if.ready);
    sb.note_word(op, pins, idx, mask);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_regs(input logic [TIMER_W-1:0] lng, input logic [TIMER_W-1:0] dbl,
                            input logic [TIMER_W-1:0] rep, input logic [SP_W-1:0] per);
    cfg_reg_t              regs[4];
    logic [CFG_DATA_W-1:0] vals[4];
    regs = '{REG_LONG, REG_DOUBLE, REG_REPEAT, REG_PERIOD};
    // upper byte of the period write is junk the register must drop
    vals = '{lng, dbl, rep, {8'($urandom), per}};
    for (int i = 0; i < 4; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
    ph_long   = lng;
    ph_double = dbl;
    ph_repeat = rep;
    ph_period = (per == 0) ? 1 : per;
  endtask

  // length in ticks of the next press or release stretch of a key
  function automatic int draw_run(bit pressing);
    int len;
    if (pressing) begin
      if ($urandom_range(0, 2) == 0)
        len = ph_long + $urandom_range(0, 4 * ph_repeat + 4 * ph_period);
      else
        len = $urandom_range(1, 3 * ph_period);
    end else begin
      if ($urandom_range(0, 1) == 0) len = $urandom_range(1, ph_double + ph_period);
      else len = ph_double + $urandom_range(ph_period, 4 * ph_period);
    end
    if (len > 600) len = $urandom_range(300, 600);
    return len;
  endfunction

  function automatic logic [FLAG_W-1:0] pick_mask();
    case ($urandom_range(0, 9))
      0, 1, 2: return 7'h7F;
      3, 4:    return FL_HOLD;
      5, 6:    return FLAG_W'(1) << $urandom_range(0, FLAG_W - 1);
      default: return FLAG_W'($urandom);
    endcase
  endfunction

  task automatic run_phase(input logic [TIMER_W-1:0] lng, input logic [TIMER_W-1:0] dbl,
                           input logic [TIMER_W-1:0] rep, input logic [SP_W-1:0] per,
                           input int n_words);
    logic [PIN_W-1:0] pins;
    drain();
    write_regs(lng, dbl, rep, per);
    for (int n = 0; n < n_words; n++) begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      if ($urandom_range(0, 3) == 0) begin
        send_word(OP_CHECK, PIN_W'($urandom), IDX_W'($urandom), pick_mask());
      end else begin
        for (int k = 0; k < PIN_W; k++) begin
          if (run_left[k] <= 0) begin
            pins_now[k] = ~pins_now[k];
            run_left[k] = draw_run(pins_now[k] == 1'b0);
          end
          run_left[k]--;
        end
        // occasional glitch word outside the key pattern
        pins = ($urandom_range(0, 11) == 0) ? PIN_W'($urandom) : pins_now;
        send_word(OP_TICK, pins, IDX_W'($urandom), FLAG_W'($urandom));
      end
    end
  endtask

  task automatic directed();
    drain();
    write_regs(16'd2, 16'd1, 16'd1, 8'd1);
    send_word(OP_CHECK, 4'hF, 2'd0, 7'h7F);
    send_word(OP_CHECK, 4'h0, 2'd3, 7'h00);
    send_word(OP_TICK, 4'h0, 2'd3, 7'h7F);
    send_word(OP_CHECK, 4'hF, 2'd1, FL_HOLD);
    send_word(OP_CHECK, 4'hF, 2'd1, FL_HOLD);
    send_word(OP_CHECK, 4'hF, 2'd1, FL_HOLD | FL_DOWN);
    // hold until long, then repeats
    repeat (4) send_word(OP_TICK, 4'h0, 2'd0, 7'h00);
    send_word(OP_CHECK, 4'h0, 2'd2, 7'h7F);
    send_word(OP_TICK, 4'hF, 2'd0, 7'h00);
    // press, release, press again on key 2
    send_word(OP_TICK, 4'b1011, 2'd0, 7'h00);
    send_word(OP_TICK, 4'hF, 2'd0, 7'h00);
    send_word(OP_TICK, 4'b1011, 2'd0, 7'h00);
    send_word(OP_TICK, 4'hF, 2'd0, 7'h00);
    // lone click on key 3 runs out the window
    send_word(OP_TICK, 4'b0111, 2'd0, 7'h00);
    repeat (3) send_word(OP_TICK, 4'hF, 2'd0, 7'h00);
    for (int k = 0; k < 4; k++) send_word(OP_CHECK, 4'h0, IDX_W'(k), 7'h7F);
  endtask

  initial begin
    int spins;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= '0;
    cfg_data         <= '0;
    in_if.valid      <= 1'b0;
    in_if.op         <= OP_TICK;
    in_if.pin_levels <= '1;
    in_if.key_index  <= '0;
    in_if.flag_mask  <= '0;
    for (int k = 0; k < PIN_W; k++) run_left[k] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed();
    run_phase(LONG_RST, DOUBLE_RST, REPEAT_RST, PERIOD_RST, 300);
    run_phase(16'd0, 16'd0, 16'd0, 8'd0, 300);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 350);
    for (int p = 0; p < 3; p++)
      run_phase(16'($urandom_range(0, 40)), 16'($urandom_range(0, 20)),
                16'($urandom_range(0, 10)), 8'($urandom_range(1, 4)), 250);
    calm = 1;
    run_phase(16'($urandom_range(0, 30)), 16'($urandom_range(0, 15)),
              16'($urandom_range(0, 8)), 8'($urandom_range(1, 3)), 300);

    in_if.valid <= 1'b0;
    spins = 0;
    while (sb.pending() != 0 && spins < 10000) begin
      @(posedge clk);
      spins++;
    end
    repeat (5) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
